/* rtl/ucr_pkg.sv */
// Shared types and constants for the canonical reordering block.
// No dependencies; imported by every other file in the block.
`timescale 1ns / 1ps
`default_nettype none

package ucr_pkg;

  localparam int CP_W        = 21;
  localparam int CLS_W       = 8;
  localparam int MAX_PENDING = 32;
  localparam int CNT_W       = $clog2(MAX_PENDING + 1);
  localparam int TDATA_W     = ((CP_W + CLS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [CP_W-1:0]  cp;
  } mark_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } chain_op_e;

  typedef struct packed {
    chain_op_e        op;
    logic [CNT_W-1:0] count;
    mark_t            new_mark;
  } chain_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_STARTER,
    ST_INSERT
  } state_e;

  typedef enum logic [1:0] {
    AFT_NONE,
    AFT_STARTER,
    AFT_MARK
  } after_e;

endpackage

`default_nettype wire

/* rtl/unicode_canonical_reorder_top.sv */
// Top level of the canonical reordering block: control, output register and chain.
// Depends on ucr_pkg and ucr_chain.
`timescale 1ns / 1ps
`default_nettype none

// Canonical ordering of combining marks. Each input item is a decomposed code
// point with its combining class. Marks (nonzero class) go into a chain of
// MAX_PENDING cells that is kept sorted by class, equal classes in arrival
// order; a mark is inserted as it is taken and the block is ready again at once.
// A starter releases the held marks from the head of the chain, one item per
// cycle unless the result side holds back, followed by the starter itself with
// tlast set; a starter with nothing held is forwarded alone with tlast set.
// A flush item (input tlast) releases the held marks with tlast on the final
// one, and yields nothing when none are held. A mark that finds the chain full
// first releases all MAX_PENDING held marks with tuser (overflow) set and tlast
// on the final one, and is then inserted. The release rate is set by the single
// read point at the head of the chain, which shifts by one cell per result.
// Results pass through one output register, and an input item is taken only
// when that register is free or being emptied in the same cycle.

module unicode_canonical_reorder_top
  import ucr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // s_axis_tdata: code_point [20:0], comb_class [28:21], zero padding above
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  input  wire logic               s_axis_tlast,   // flush: end of string
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // m_axis_tdata: out_code_point [20:0], out_class [28:21], zero padding above
  output logic [TDATA_W-1:0]      m_axis_tdata,
  output logic                    m_axis_tlast,   // last result of this input item
  output logic                    m_axis_tuser,   // overflow
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready
);

  state_e           state_q, state_d;
  after_e           after_q, after_d;
  logic             final_q, final_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] count_q, count_d;
  mark_t            save_q;
  logic             save_load;

  logic             out_valid_q;
  mark_t            out_mark_q, out_mark_d;
  logic             out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;
  logic             out_load;
  logic             load_ok;

  mark_t            in_mark;
  logic             acc;
  logic             is_full;
  chain_ctrl_t      ctrl;
  mark_t            head;

  assign in_mark.cp  = s_axis_tdata[CP_W-1:0];
  assign in_mark.cls = s_axis_tdata[CP_W+CLS_W-1:CP_W];

  // The output register may be reloaded when empty or emptied this cycle.
  assign load_ok = !out_valid_q || m_axis_tready;
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign is_full = count_q == CNT_W'(MAX_PENDING);

  ucr_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (s_axis_tlast || in_mark.cls == '0) begin
            if (count_q != '0) begin
              state_d = ST_DRAIN;
            end
          end else if (is_full) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load_ok && count_q == CNT_W'(1)) begin
          unique case (after_q)
            AFT_STARTER: state_d = ST_STARTER;
            AFT_MARK:    state_d = ST_INSERT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_STARTER: begin
        if (load_ok) begin
          state_d = ST_IDLE;
        end
      end
      ST_INSERT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller: chain command, output register load, saved item.
  always_comb begin
    s_axis_tready = 1'b0;
    ctrl.op       = OP_HOLD;
    ctrl.count    = count_q;
    ctrl.new_mark = in_mark;
    count_d       = count_q;
    out_load      = 1'b0;
    out_mark_d    = in_mark;
    out_last_d    = 1'b0;
    out_ovf_d     = 1'b0;
    save_load     = 1'b0;
    after_d       = after_q;
    final_d       = final_q;
    ovf_d         = ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = load_ok;
        if (acc) begin
          if (s_axis_tlast) begin
            final_d = 1'b1;
            ovf_d   = 1'b0;
            after_d = AFT_NONE;
          end else if (in_mark.cls == '0) begin
            if (count_q == '0) begin
              out_load   = 1'b1;
              out_last_d = 1'b1;
            end else begin
              save_load = 1'b1;
              after_d   = AFT_STARTER;
              final_d   = 1'b0;
              ovf_d     = 1'b0;
            end
          end else if (is_full) begin
            save_load = 1'b1;
            after_d   = AFT_MARK;
            final_d   = 1'b1;
            ovf_d     = 1'b1;
          end else begin
            ctrl.op = OP_INSERT;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (load_ok) begin
          out_load   = 1'b1;
          out_mark_d = head;
          out_last_d = final_q && (count_q == CNT_W'(1));
          out_ovf_d  = ovf_q;
          ctrl.op    = OP_SHIFT;
          count_d    = count_q - CNT_W'(1);
        end
      end
      ST_STARTER: begin
        if (load_ok) begin
          out_load   = 1'b1;
          out_mark_d = save_q;
          out_last_d = 1'b1;
        end
      end
      ST_INSERT: begin
        ctrl.op       = OP_INSERT;
        ctrl.new_mark = save_q;
        count_d       = count_q + CNT_W'(1);
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      after_q     <= AFT_NONE;
      final_q     <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      final_q <= final_d;
      ovf_q   <= ovf_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (save_load) begin
      save_q <= in_mark;
    end
    if (out_load) begin
      out_mark_q <= out_mark_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= out_ovf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TDATA_W - CP_W - CLS_W){1'b0}}, out_mark_q.cls, out_mark_q.cp};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

  // The number of held marks never exceeds the chain length.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PENDING))
    else $error("held mark count beyond chain length");

  // Draining only ever happens with marks held.
  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> count_q != '0)
    else $error("drain with empty chain");

  // Each released mark lowers the count by exactly one.
  a_drain_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && load_ok) |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("drain step did not decrement count");

  // A starter with nothing held comes out on the next cycle as a last item.
  a_lone_starter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !s_axis_tlast && in_mark.cls == '0 && count_q == '0)
      |=> (m_axis_tvalid && m_axis_tlast && !m_axis_tuser))
    else $error("lone starter not forwarded");

endmodule

`default_nettype wire

/* rtl/ucr_cell.sv */
// One cell of the sorted mark chain: holds a single (class, code point) pair.
// Depends on ucr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucr_cell
  import ucr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire chain_op_e op_i,
  input  wire logic      occupied_i,
  input  wire mark_t     new_mark_i,
  input  wire logic      prev_take_i,
  input  wire mark_t     prev_mark_i,
  input  wire mark_t     next_mark_i,
  output logic           take_o,
  output mark_t          mark_o
);

  mark_t mark_q, mark_d;

  // An empty cell, or one whose class is strictly greater, yields its place.
  assign take_o = !occupied_i || (mark_q.cls > new_mark_i.cls);
  assign mark_o = mark_q;

  always_comb begin
    mark_d = mark_q;
    case (op_i)
      OP_INSERT: begin
        if (take_o) begin
          mark_d = prev_take_i ? prev_mark_i : new_mark_i;
        end
      end
      OP_SHIFT: mark_d = next_mark_i;
      default:  mark_d = mark_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mark_q <= mark_d;
  end

endmodule

`default_nettype wire

/* rtl/ucr_chain.sv */
// Row of ucr_cell instances kept sorted by class; cell 0 is the head.
// Depends on ucr_pkg and ucr_cell.
`timescale 1ns / 1ps
`default_nettype none

module ucr_chain
  import ucr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire chain_ctrl_t ctrl_i,
  output mark_t            head_o
);

  logic  take  [MAX_PENDING];
  mark_t marks [MAX_PENDING];

  for (genvar i = 0; i < MAX_PENDING; i++) begin : g_cell
    logic  occupied;
    logic  prev_take;
    mark_t prev_mark;
    mark_t next_mark;

    assign occupied = CNT_W'(i) < ctrl_i.count;

    if (i == 0) begin : g_first
      assign prev_take = 1'b0;
      assign prev_mark = ctrl_i.new_mark;
    end else begin : g_rest
      assign prev_take = take[i-1];
      assign prev_mark = marks[i-1];
    end

    if (i == MAX_PENDING - 1) begin : g_tail
      assign next_mark = '0;
    end else begin : g_mid
      assign next_mark = marks[i+1];
    end

    ucr_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (ctrl_i.op),
      .occupied_i  (occupied),
      .new_mark_i  (ctrl_i.new_mark),
      .prev_take_i (prev_take),
      .prev_mark_i (prev_mark),
      .next_mark_i (next_mark),
      .take_o      (take[i]),
      .mark_o      (marks[i])
    );
  end

  assign head_o = marks[0];

endmodule

`default_nettype wire
